// ===== design/bfra_pkg.sv =====
// ----------------------------------------------------------------------------
// bfra_pkg: shared definitions of the best-fit range allocator
// Field widths, default sizes, result codes and the command and status
// structures that join the controller to the datapath.
// ----------------------------------------------------------------------------
package bfra_pkg;

	localparam int MAX_GAPS_DEF  = 64;
	localparam int ADDR_BITS_DEF = 40;

	localparam int LEN_W   = 41;
	localparam int OFF_W   = 40;
	localparam int ALIGN_W = 32;
	localparam int STAT_W  = 2;

	localparam logic [STAT_W-1:0] STATUS_OK         = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_NO_FIT     = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_TABLE_FULL = 2'd2;

	localparam logic ACT_RESERVE = 1'b0;
	localparam logic ACT_FREE    = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // capture a new request, restart the scan
		logic rd;      // read the table entry under the scan index
		logic div_go;  // start the remainder unit on the entry just read
		logic eval;    // judge the entry and advance the scan index
		logic apply;   // update the table and present the result
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_div;  // entry needs its alignment remainder
		logic last;      // scan index is on the final entry
		logic div_done;  // remainder is ready
	} stat_t;

endpackage

// ===== design/best_fit_range_allocator.sv =====
// ----------------------------------------------------------------------------
// best_fit_range_allocator: best-fit free-gap allocator with coalescing
// Keeps a table of free gaps; reserve requests take the smallest fitting gap,
// free requests return ranges and merge them with touching gaps.
// ----------------------------------------------------------------------------
// A request is taken when start is high while busy is low. Each request gives
// exactly one result, shown for a single cycle with done high; the receiver
// cannot hold it off, so it must capture the result in that cycle. The block
// walks the whole gap table once per request, one entry at a time through a
// single memory read port. With a non-zero alignment every valid entry of a
// reserve also passes through the bit-serial remainder unit before it is
// judged. The table starts empty after reset, so software first frees the
// whole heap. A new request may be given in the cycle in which done is shown.
// ----------------------------------------------------------------------------
module best_fit_range_allocator #(
	parameter int MAX_GAPS  = bfra_pkg::MAX_GAPS_DEF,
	parameter int ADDR_BITS = bfra_pkg::ADDR_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          action,
	input  logic [bfra_pkg::LEN_W-1:0]    length,
	input  logic [bfra_pkg::OFF_W-1:0]    range_offset,
	input  logic [bfra_pkg::ALIGN_W-1:0]  alignment,
	output logic                          done,
	output logic [bfra_pkg::STAT_W-1:0]   status,
	output logic [bfra_pkg::OFF_W-1:0]    block_offset,
	output logic [bfra_pkg::LEN_W-1:0]    block_length,
	output logic [bfra_pkg::OFF_W-1:0]    usable_offset
);

	bfra_pkg::cmd_t  cmd;
	bfra_pkg::stat_t stat;

	// The controller sequences read, remainder, judgement and update.
	bfra_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.stat   (stat)
	);

	// The datapath holds the table and the running best-fit and neighbour
	// choices, and registers the result.
	bfra_dp #(
		.MAX_GAPS  (MAX_GAPS),
		.ADDR_BITS (ADDR_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.action        (action),
		.length        (length),
		.range_offset  (range_offset),
		.alignment     (alignment),
		.done          (done),
		.status        (status),
		.block_offset  (block_offset),
		.block_length  (block_length),
		.usable_offset (usable_offset)
	);

endmodule

// ===== design/bfra_rem.sv =====
// ----------------------------------------------------------------------------
// bfra_rem: iterative remainder unit
// Restoring division of a gap start by the alignment, one dividend bit per
// cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module bfra_rem #(
	parameter int ADDR_BITS = bfra_pkg::ADDR_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         go,
	input  logic [ADDR_BITS-1:0]         dividend,
	input  logic [bfra_pkg::ALIGN_W-1:0] divisor,
	output logic [bfra_pkg::ALIGN_W-1:0] rem,
	output logic                         done
);

	localparam int CNT_W = $clog2(ADDR_BITS + 1);

	logic [ADDR_BITS-1:0]         dvd_q;
	logic [bfra_pkg::ALIGN_W-1:0] rem_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         run_q;
	logic                         done_q;
	logic [bfra_pkg::ALIGN_W:0]   trial;
	logic [bfra_pkg::ALIGN_W:0]   diff;

	assign trial = {rem_q, dvd_q[ADDR_BITS-1]};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ADDR_BITS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[ADDR_BITS-2:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				rem_q <= diff[bfra_pkg::ALIGN_W-1:0];
			end else begin
				rem_q <= trial[bfra_pkg::ALIGN_W-1:0];
			end
		end
	end

	assign rem  = rem_q;
	assign done = done_q;

endmodule

// ===== design/bfra_dp.sv =====
// ----------------------------------------------------------------------------
// bfra_dp: datapath of the best-fit range allocator
// Gap table memory, valid bits, scan index, best-fit and neighbour tracking,
// table update and result registers.
// ----------------------------------------------------------------------------
module bfra_dp #(
	parameter int MAX_GAPS  = bfra_pkg::MAX_GAPS_DEF,
	parameter int ADDR_BITS = bfra_pkg::ADDR_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bfra_pkg::cmd_t                cmd,
	output bfra_pkg::stat_t               stat,
	input  logic                          action,
	input  logic [bfra_pkg::LEN_W-1:0]    length,
	input  logic [bfra_pkg::OFF_W-1:0]    range_offset,
	input  logic [bfra_pkg::ALIGN_W-1:0]  alignment,
	output logic                          done,
	output logic [bfra_pkg::STAT_W-1:0]   status,
	output logic [bfra_pkg::OFF_W-1:0]    block_offset,
	output logic [bfra_pkg::LEN_W-1:0]    block_length,
	output logic [bfra_pkg::OFF_W-1:0]    usable_offset
);

	localparam int IW = $clog2(MAX_GAPS);
	localparam int SW = ADDR_BITS + 1;
	localparam int LW = (SW > bfra_pkg::LEN_W) ? SW : bfra_pkg::LEN_W;
	localparam int CW = LW + 1;

	logic [ADDR_BITS-1:0] mem_start [MAX_GAPS];
	logic [SW-1:0]        mem_size  [MAX_GAPS];
	logic [MAX_GAPS-1:0]  used_q;

	logic                         act_q;
	logic [LW-1:0]                len_q;
	logic [ADDR_BITS-1:0]         off_q;
	logic [SW-1:0]                end_q;
	logic [bfra_pkg::ALIGN_W-1:0] align_q;
	logic [IW-1:0]                idx_q;

	logic [ADDR_BITS-1:0] rd_start_q;
	logic [SW-1:0]        rd_size_q;
	logic                 rd_used_q;

	logic                         best_found_q;
	logic [IW-1:0]                best_idx_q;
	logic [ADDR_BITS-1:0]         best_start_q;
	logic [SW-1:0]                best_size_q;
	logic [CW-1:0]                best_need_q;
	logic [bfra_pkg::ALIGN_W-1:0] best_pad_q;

	logic                 left_found_q, right_found_q, slot_found_q;
	logic [IW-1:0]        left_idx_q, right_idx_q, slot_idx_q;
	logic [ADDR_BITS-1:0] left_start_q;
	logic [SW-1:0]        left_size_q, right_size_q;

	logic                         done_q;
	logic [bfra_pkg::STAT_W-1:0]  status_q;
	logic [bfra_pkg::OFF_W-1:0]   boff_q, uoff_q;
	logic [bfra_pkg::LEN_W-1:0]   blen_q;

	// load-time arithmetic
	logic [ADDR_BITS-1:0] off_in;
	logic [LW:0]          room;
	logic [LW-1:0]        len_in, len_clip;

	// per-entry arithmetic
	logic [bfra_pkg::ALIGN_W-1:0] rem;
	logic                         rem_done;
	logic [bfra_pkg::ALIGN_W-1:0] pad;
	logic [CW-1:0]                need;
	logic                         fits, better;
	logic [SW-1:0]                rd_end;

	// table write port
	logic                 we;
	logic [IW-1:0]        waddr;
	logic [ADDR_BITS-1:0] wstart;
	logic [SW-1:0]        wsize;

	bfra_rem #(.ADDR_BITS(ADDR_BITS)) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.div_go),
		.dividend (rd_start_q),
		.divisor  (align_q),
		.rem      (rem),
		.done     (rem_done)
	);

	assign off_in   = ADDR_BITS'(range_offset);
	assign room     = (LW+1)'(1) << ADDR_BITS;
	assign len_in   = LW'(length);
	assign len_clip = ((LW+1)'(len_in) > room - (LW+1)'(off_in)) ?
		LW'(room - (LW+1)'(off_in)) : len_in;

	assign pad = (align_q == '0 || rem == '0) ? '0 : align_q - rem;
	assign need = CW'(len_q) + CW'(pad);
	assign fits = CW'(rd_size_q) >= need;
	assign better = !best_found_q || rd_size_q < best_size_q ||
		(rd_size_q == best_size_q && rd_start_q < best_start_q);
	assign rd_end = SW'(rd_start_q) + rd_size_q;

	assign stat.need_div = (act_q == bfra_pkg::ACT_RESERVE) && rd_used_q &&
		(align_q != '0);
	assign stat.last     = (idx_q == IW'(MAX_GAPS - 1));
	assign stat.div_done = rem_done;

	// Table update decided at the end of the scan.
	always_comb begin
		we     = 1'b0;
		waddr  = best_idx_q;
		wstart = best_start_q + ADDR_BITS'(best_need_q);
		wsize  = rd_size_q;
		if (cmd.apply) begin
			if (act_q == bfra_pkg::ACT_RESERVE) begin
				wsize = best_size_q - SW'(best_need_q);
				we    = best_found_q && (CW'(best_size_q) != best_need_q);
			end else if (len_q != '0) begin
				priority if (left_found_q) begin
					we     = 1'b1;
					waddr  = left_idx_q;
					wstart = left_start_q;
					wsize  = left_size_q + SW'(len_q) +
						(right_found_q ? right_size_q : '0);
				end else if (right_found_q) begin
					we     = 1'b1;
					waddr  = right_idx_q;
					wstart = off_q;
					wsize  = right_size_q + SW'(len_q);
				end else begin
					we     = slot_found_q;
					waddr  = slot_idx_q;
					wstart = off_q;
					wsize  = SW'(len_q);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_start[waddr] <= wstart;
			mem_size[waddr]  <= wsize;
		end
		if (cmd.rd) begin
			rd_start_q <= mem_start[idx_q];
			rd_size_q  <= mem_size[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.apply;
			if (cmd.apply) begin
				if (act_q == bfra_pkg::ACT_RESERVE) begin
					if (best_found_q && CW'(best_size_q) == best_need_q) begin
						used_q[best_idx_q] <= 1'b0;
					end
				end else if (len_q != '0) begin
					if (left_found_q) begin
						if (right_found_q) begin
							used_q[right_idx_q] <= 1'b0;
						end
					end else if (!right_found_q && slot_found_q) begin
						used_q[slot_idx_q] <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q         <= action;
			len_q         <= (action == bfra_pkg::ACT_FREE) ? len_clip : len_in;
			off_q         <= off_in;
			end_q         <= SW'(off_in) + SW'(len_clip);
			align_q       <= alignment;
			idx_q         <= '0;
			best_found_q  <= 1'b0;
			left_found_q  <= 1'b0;
			right_found_q <= 1'b0;
			slot_found_q  <= 1'b0;
		end
		if (cmd.rd) begin
			rd_used_q <= used_q[idx_q];
		end
		if (cmd.eval) begin
			idx_q <= idx_q + 1'b1;
			if (act_q == bfra_pkg::ACT_RESERVE) begin
				if (rd_used_q && fits && better) begin
					best_found_q <= 1'b1;
					best_idx_q   <= idx_q;
					best_start_q <= rd_start_q;
					best_size_q  <= rd_size_q;
					best_need_q  <= need;
					best_pad_q   <= pad;
				end
			end else if (rd_used_q) begin
				if (!left_found_q && rd_end == SW'(off_q)) begin
					left_found_q <= 1'b1;
					left_idx_q   <= idx_q;
					left_start_q <= rd_start_q;
					left_size_q  <= rd_size_q;
				end else if (!right_found_q && SW'(rd_start_q) == end_q) begin
					right_found_q <= 1'b1;
					right_idx_q   <= idx_q;
					right_size_q  <= rd_size_q;
				end
			end else if (!slot_found_q) begin
				slot_found_q <= 1'b1;
				slot_idx_q   <= idx_q;
			end
		end
		if (cmd.apply) begin
			status_q <= bfra_pkg::STATUS_OK;
			boff_q   <= '0;
			blen_q   <= '0;
			uoff_q   <= '0;
			if (act_q == bfra_pkg::ACT_RESERVE) begin
				if (best_found_q) begin
					boff_q <= bfra_pkg::OFF_W'(best_start_q);
					blen_q <= bfra_pkg::LEN_W'(best_need_q);
					uoff_q <= bfra_pkg::OFF_W'(best_start_q + ADDR_BITS'(best_pad_q));
				end else begin
					status_q <= bfra_pkg::STATUS_NO_FIT;
				end
			end else if (len_q != '0 && !left_found_q && !right_found_q &&
				!slot_found_q) begin
				status_q <= bfra_pkg::STATUS_TABLE_FULL;
			end
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign block_offset  = boff_q;
	assign block_length  = blen_q;
	assign usable_offset = uoff_q;

endmodule

// ===== design/bfra_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfra_ctrl: controller of the best-fit range allocator
// Steps the datapath through one table scan per request and the update.
// ----------------------------------------------------------------------------
module bfra_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	output bfra_pkg::cmd_t  cmd,
	input  bfra_pkg::stat_t stat
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_READ  = 6'b000010,
		S_DATA  = 6'b000100,
		S_DIV   = 6'b001000,
		S_EVAL  = 6'b010000,
		S_APPLY = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_READ;
				end
			end
			S_READ: begin
				cmd.rd  = 1'b1;
				state_d = S_DATA;
			end
			S_DATA: begin
				if (stat.need_div) begin
					cmd.div_go = 1'b1;
					state_d    = S_DIV;
				end else begin
					state_d = S_EVAL;
				end
			end
			S_DIV: begin
				if (stat.div_done) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = stat.last ? S_APPLY : S_READ;
			end
			S_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule
